FILE: rtl/kvat_pkg.sv
// ---------------------------------------------------------------------------
// kvat_pkg: shared definitions for the key and value association table
// Holds the field widths of the ports, the opcode values, the control
// state type and the command that the top level sends to every cell.
// ---------------------------------------------------------------------------
package kvat_pkg;

  // Fixed widths of the item fields on the ports.
  localparam int unsigned KeyPortW   = 32;
  localparam int unsigned ValuePortW = 32;
  localparam int unsigned PosPortW   = 4;
  localparam int unsigned CountPortW = 5;

  // Opcode values.
  localparam logic OpPut    = 1'b0;
  localparam logic OpLookup = 1'b1;

  // Control states of the top level.
  typedef enum logic {
    ST_IDLE,
    ST_RESOLVE
  } kvat_state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic compare;    // capture the match flag against the incoming key
    logic shift;      // take the neighbor's entry (insert at the head)
    logic write_hit;  // overwrite the value if this cell matched
  } kvat_cmd_t;

endpackage

FILE: rtl/kvat_cell.sv
// ---------------------------------------------------------------------------
// kvat_cell: one entry of the association table
// Holds a key, a value and a valid flag, compares its key with the incoming
// one and passes its entry to the next cell when the chain shifts.
// ---------------------------------------------------------------------------
module kvat_cell #(
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kvat_pkg::kvat_cmd_t     cmd_i,
  input  logic [KEY_WIDTH-1:0]    key_i,
  input  logic [VALUE_WIDTH-1:0]  value_i,
  input  logic [KEY_WIDTH-1:0]    prev_key_i,
  input  logic [VALUE_WIDTH-1:0]  prev_value_i,
  input  logic                    prev_valid_i,
  output logic [KEY_WIDTH-1:0]    key_o,
  output logic [VALUE_WIDTH-1:0]  value_o,
  output logic                    valid_o,
  output logic                    match_o
);

  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   valid_q;
  logic                   match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (cmd_i.compare) begin
        match_q <= valid_q && (key_q == key_i);
      end
      if (cmd_i.shift) begin
        valid_q <= prev_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end else if (cmd_i.write_hit && match_q) begin
      value_q <= value_i;
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

FILE: rtl/key_value_association_table.sv
// ---------------------------------------------------------------------------
// key_value_association_table: bounded associative table, newest first
// A chain of cells holds up to ENTRIES key and value pairs. A put overwrites
// the value of a matching key, else inserts a new pair at the head, shifting
// the chain by one cell, or is refused if full; a lookup reports the matching entry.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  -------------------------------
//  in       into       in_valid_i / in_stall_o   opcode_i, key_in_i, value_in_i
//  out      out of     out_valid_o / out_stall_i found_o, position_o,
//                                                value_out_o, entry_count_o,
//                                                full_error_o
//
//  For each item, at the transfer every cell compares its key with the
//  incoming key and registers a match flag; then, in the resolve state and
//  once the output register is free, the match flags are combined into the
//  result and the cells are updated. A new item is taken again in the cycle
//  after that, so the table takes no new item before the last is resolved.
//  A result waits in the output register; the table only holds its update
//  when a finished result is still waiting there.
//  Reset empties the table at once (valid and match flags only); no clearing pass.
//
module key_value_association_table #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [kvat_pkg::KeyPortW-1:0]       key_in_i,
  input  logic [kvat_pkg::ValuePortW-1:0]     value_in_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [kvat_pkg::PosPortW-1:0]       position_o,
  output logic [kvat_pkg::ValuePortW-1:0]     value_out_o,
  output logic [kvat_pkg::CountPortW-1:0]     entry_count_o,
  output logic                                full_error_o
);

  // Widths derived from the table size.
  localparam int unsigned IdxW   = $clog2(ENTRIES);
  localparam int unsigned CntW   = $clog2(ENTRIES + 1);
  localparam int unsigned PosExt = (IdxW > kvat_pkg::PosPortW) ? IdxW : kvat_pkg::PosPortW;
  localparam int unsigned CntExt = (CntW > kvat_pkg::CountPortW) ? CntW
                                                                 : kvat_pkg::CountPortW;
  localparam int unsigned KeyExt = (KEY_WIDTH > kvat_pkg::KeyPortW) ? KEY_WIDTH
                                                                    : kvat_pkg::KeyPortW;
  localparam int unsigned ValExt = (VALUE_WIDTH > kvat_pkg::ValuePortW) ? VALUE_WIDTH
                                                                        : kvat_pkg::ValuePortW;

  // Control state and the captured item.
  kvat_pkg::kvat_state_e  state_q, state_d;
  logic                   op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CntW-1:0]        count_q, count_d;

  // Output register.
  logic                              out_valid_q;
  logic                              found_q;
  logic [kvat_pkg::PosPortW-1:0]     position_q;
  logic [kvat_pkg::ValuePortW-1:0]   value_out_q;
  logic [kvat_pkg::CountPortW-1:0]   entry_count_q;
  logic                              full_error_q;

  // Chain signals.
  kvat_pkg::kvat_cmd_t    cmd;
  logic [KEY_WIDTH-1:0]   cell_key   [ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0]     cell_valid;
  logic [ENTRIES-1:0]     cell_match;

  // The incoming key and value, cut or zero-extended to the stored widths.
  logic [KeyExt-1:0]      key_ext;
  logic [ValExt-1:0]      value_ext;
  logic [KEY_WIDTH-1:0]   key_in;
  logic [VALUE_WIDTH-1:0] value_in;

  // Resolution of the registered match flags.
  logic                   in_accept;
  logic                   out_free;
  logic                   hit;
  logic                   full;
  logic                   is_put;
  logic                   do_insert;
  logic [IdxW-1:0]        hit_idx;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [PosExt-1:0]      pos_ext;
  logic [ValExt-1:0]      hit_value_ext;
  logic [CntExt-1:0]      count_ext;

  assign key_ext   = KeyExt'(key_in_i);
  assign value_ext = ValExt'(value_in_i);
  assign key_in    = key_ext[KEY_WIDTH-1:0];
  assign value_in  = value_ext[VALUE_WIDTH-1:0];

  assign in_accept = in_valid_i && !in_stall_o;
  // The output register can take a new result when it is empty or is being
  // drained in this very cycle.
  assign out_free  = !(out_valid_q && out_stall_i);

  // The chain of cells. Cell 0 is the newest entry; on an insert it takes
  // the new pair and every other cell takes its neighbor's entry.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   prev_key;
    logic [VALUE_WIDTH-1:0] prev_value;
    logic                   prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = key_q;
      assign prev_value = value_q;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    kvat_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_i        (key_in),
      .value_i      (value_q),
      .prev_key_i   (prev_key),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (cell_match[i])
    );
  end

  // Keys are never duplicated, so at most one cell matches and the position
  // and value of the hit are plain OR reductions over the cells.
  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_idx   = hit_idx | IdxW'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
  end

  assign hit       = |cell_match;
  // Valid flags fill from the head, so the last cell is valid only when full.
  assign full      = cell_valid[ENTRIES-1];
  assign is_put    = (op_q == kvat_pkg::OpPut);
  assign do_insert = is_put && !hit && !full;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kvat_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = kvat_pkg::ST_RESOLVE;
        end
      end
      kvat_pkg::ST_RESOLVE: begin
        if (out_free) begin
          state_d = kvat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kvat_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine: the stall and the command to the cells.
  always_comb begin
    in_stall_o    = 1'b1;
    cmd.compare   = 1'b0;
    cmd.shift     = 1'b0;
    cmd.write_hit = 1'b0;
    case (state_q)
      kvat_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd.compare = in_valid_i;
      end
      kvat_pkg::ST_RESOLVE: begin
        cmd.shift     = out_free && do_insert;
        cmd.write_hit = out_free && is_put && hit;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign count_d       = cmd.shift ? (count_q + CntW'(1)) : count_q;
  assign pos_ext       = PosExt'(hit_idx);
  assign hit_value_ext = ValExt'(hit_value);
  assign count_ext     = CntExt'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvat_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == kvat_pkg::ST_RESOLVE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Captured item and result fields carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= opcode_i;
      key_q   <= key_in;
      value_q <= value_in;
    end
    if ((state_q == kvat_pkg::ST_RESOLVE) && out_free) begin
      found_q       <= hit;
      position_q    <= pos_ext[kvat_pkg::PosPortW-1:0];
      value_out_q   <= (!is_put && hit) ? hit_value_ext[kvat_pkg::ValuePortW-1:0] : '0;
      entry_count_q <= count_ext[kvat_pkg::CountPortW-1:0];
      full_error_q  <= is_put && !hit && full;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign position_o    = position_q;
  assign value_out_o   = value_out_q;
  assign entry_count_o = entry_count_q;
  assign full_error_o  = full_error_q;

  // The count tracks the number of valid cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("entry count disagrees with the valid cells");

  // Valid cells form an unbroken run from the head of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + ENTRIES'(1))) == '0)
    else $error("valid cells are not contiguous from the head");

  // Keys are unique, so no two cells may match the same key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvat_pkg::ST_RESOLVE) |-> $onehot0(cell_match))
    else $error("more than one cell matched the key");

  // A refused put never reports a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_error_o && found_o))
    else $error("full error reported together with a hit");

  // An insert grows the table by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance the entry count");

endmodule

FILE: bench/kvat_result_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kvat_result_check: result prediction and comparison for the table
// Watches both channels of the table, keeps its own copy of the entries,
// predicts one result per input transfer and compares every output transfer
// against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module kvat_result_check #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              opcode_i,
  input  logic [kvat_pkg::KeyPortW-1:0]     key_in_i,
  input  logic [kvat_pkg::ValuePortW-1:0]   value_in_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              found_i,
  input  logic [kvat_pkg::PosPortW-1:0]     position_i,
  input  logic [kvat_pkg::ValuePortW-1:0]   value_out_i,
  input  logic [kvat_pkg::CountPortW-1:0]   entry_count_i,
  input  logic                              full_error_i,
  output int                                mismatches_o,
  output int                                pending_o
);

  localparam int MaxReports = 10;

  typedef struct packed {
    logic                            found;
    logic [kvat_pkg::PosPortW-1:0]   position;
    logic [kvat_pkg::ValuePortW-1:0] value;
    logic [kvat_pkg::CountPortW-1:0] entries;
    logic                            full_error;
  } table_result_t;

  // Local copy of the table, newest entry at index 0.
  logic [kvat_pkg::KeyPortW-1:0]   table_keys[ENTRIES];
  logic [kvat_pkg::ValuePortW-1:0] table_values[ENTRIES];
  int                              table_fill = 0;

  table_result_t awaited_results[$];
  table_result_t seen_result;
  table_result_t want_result;
  int            mismatch_total = 0;

  // Applies one item to the local table and returns the result it causes.
  function automatic table_result_t apply_table_item(
    logic op, logic [kvat_pkg::KeyPortW-1:0] key, logic [kvat_pkg::ValuePortW-1:0] value);
    table_result_t res;
    int            hit_at;
    int            i;
    res    = '0;
    hit_at = -1;
    for (i = 0; i < table_fill; i++) begin
      if (hit_at < 0 && table_keys[i] == key) begin
        hit_at = i;
      end
    end
    if (op == kvat_pkg::OpPut) begin
      if (hit_at >= 0) begin
        table_values[hit_at] = value;
      end else if (table_fill >= ENTRIES) begin
        res.full_error = 1'b1;
      end else begin
        for (i = table_fill; i > 0; i--) begin
          table_keys[i]   = table_keys[i-1];
          table_values[i] = table_values[i-1];
        end
        table_keys[0]   = key;
        table_values[0] = value;
        table_fill++;
      end
    end else if (hit_at >= 0) begin
      res.value = table_values[hit_at];
    end
    if (hit_at >= 0) begin
      res.found    = 1'b1;
      res.position = hit_at[kvat_pkg::PosPortW-1:0];
    end
    res.entries = table_fill[kvat_pkg::CountPortW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      table_fill     = 0;
      mismatch_total = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      // The result of an item always leaves after its transfer, so results
      // are retired before this edge's input is predicted.
      if (out_valid_i && !out_stall_i) begin
        seen_result = '{found_i, position_i, value_out_i, entry_count_i, full_error_i};
        if (awaited_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= MaxReports) begin
            $display("%0t: result transfer with nothing awaited: found=%0d pos=%0d value=%h "
                     , $realtime, seen_result.found, seen_result.position, seen_result.value,
                     "count=%0d full=%0d", seen_result.entries, seen_result.full_error);
          end
        end else begin
          want_result = awaited_results.pop_front();
          if (seen_result !== want_result) begin
            mismatch_total++;
            if (mismatch_total <= MaxReports) begin
              $display("%0t: result mismatch, expected found=%0d pos=%0d value=%h count=%0d ",
                       $realtime, want_result.found, want_result.position, want_result.value,
                       want_result.entries, "full=%0d, actual found=%0d pos=%0d value=%h ",
                       want_result.full_error, seen_result.found, seen_result.position,
                       seen_result.value, "count=%0d full=%0d", seen_result.entries,
                       seen_result.full_error);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_table_item(opcode_i, key_in_i, value_in_i));
      end
      pending_o    <= awaited_results.size();
      mismatches_o <= mismatch_total;
    end
  end

endmodule

FILE: bench/key_value_association_table_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// key_value_association_table_test: stimulus for the association table
// Drives a directed opening and then random put and lookup items into the
// table, with random idle cycles on both channels, and reports the verdict
// based on the failure and pending counts of the result check.
// ---------------------------------------------------------------------------
module key_value_association_table_test;

  localparam int ClkPeriod     = 20;
  localparam int ResetCycles   = 7;
  localparam int Entries       = 16;
  localparam int PhaseItems    = 440;
  localparam int PhaseCount    = 4;
  localparam int WatchdogLimit = 1000;
  // The table finishes one item before it takes the next, so this much quiet
  // after the last result is plenty to catch any stray output.
  localparam int DrainCycles   = 8;

  logic                            clk      = 1'b0;
  logic                            rst_n    = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            opcode   = kvat_pkg::OpPut;
  logic [kvat_pkg::KeyPortW-1:0]   key_in   = '0;
  logic [kvat_pkg::ValuePortW-1:0] value_in = '0;
  logic                            out_stall = 1'b0;

  logic                            in_stall;
  logic                            out_valid;
  logic                            found;
  logic [kvat_pkg::PosPortW-1:0]   position;
  logic [kvat_pkg::ValuePortW-1:0] value_out;
  logic [kvat_pkg::CountPortW-1:0] entry_count;
  logic                            full_error;

  int mismatches;
  int pending;
  int idle_cycles = 0;

  // When set, the matching side of the bench runs without any idle cycles.
  logic calm_source = 1'b0;
  logic calm_sink   = 1'b0;

  // Keys that the directed opening stores; the table is full after it, so
  // these stay the only keys that can ever hit.
  logic [kvat_pkg::KeyPortW-1:0] stored_keys[Entries];

  always #(ClkPeriod / 2) clk = ~clk;

  key_value_association_table #(
    .ENTRIES    (Entries),
    .KEY_WIDTH  (kvat_pkg::KeyPortW),
    .VALUE_WIDTH(kvat_pkg::ValuePortW)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .key_in_i     (key_in),
    .value_in_i   (value_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .found_o      (found),
    .position_o   (position),
    .value_out_o  (value_out),
    .entry_count_o(entry_count),
    .full_error_o (full_error)
  );

  kvat_result_check #(
    .ENTRIES(Entries)
  ) i_result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .key_in_i     (key_in),
    .value_in_i   (value_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .found_i      (found),
    .position_i   (position),
    .value_out_i  (value_out),
    .entry_count_i(entry_count),
    .full_error_i (full_error),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Offers one item after a random gap and returns at the edge where the
  // transfer takes place. Valid stays high into the next item when that item
  // has no gap, so valid is never dropped and raised in the same step.
  task automatic send_item(input logic op, input logic [kvat_pkg::KeyPortW-1:0] key,
                           input logic [kvat_pkg::ValuePortW-1:0] value);
    int gap;
    gap = calm_source ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_in   <= key;
    value_in <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Random item: mostly keys that are in the table, so that hits land on
  // every position, plus fresh keys and near misses that differ from a
  // stored key in a single bit.
  task automatic send_random_item();
    logic                          op;
    logic [kvat_pkg::KeyPortW-1:0] key;
    int                            pick;
    op   = $urandom_range(0, 1) ? kvat_pkg::OpLookup : kvat_pkg::OpPut;
    pick = $urandom_range(0, 7);
    key  = stored_keys[$urandom_range(0, Entries - 1)];
    if (pick == 6) begin
      key = $urandom;
    end else if (pick == 7) begin
      key = key ^ (kvat_pkg::KeyPortW'(1) << $urandom_range(0, kvat_pkg::KeyPortW - 1));
    end
    send_item(op, key, $urandom);
  endtask

  // Waits until every predicted result has been transferred. The pending
  // count is registered, so the task always waits on the clock before trusting it.
  task automatic wait_for_results();
    do @(posedge clk); while (pending != 0);
  endtask

  // The receiving side stalls for a random number of cycles before each
  // result and then takes it as soon as it is offered.
  initial begin : result_sink
    int wait_cycles;
    forever begin
      wait_cycles = calm_sink ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // A run that stops making progress ends here instead of hanging.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int phase;
    stored_keys[0] = '0;
    stored_keys[1] = '1;
    for (i = 2; i < Entries; i++) begin
      stored_keys[i] = kvat_pkg::KeyPortW'(i - 1) * 32'h1111_1111;
    end

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. A lookup on the empty table must miss, then the
    // extreme keys go in and are found at the positions that follow from
    // newest-first ordering.
    send_item(kvat_pkg::OpLookup, '0, '1);
    send_item(kvat_pkg::OpPut, stored_keys[0], '1);
    send_item(kvat_pkg::OpPut, stored_keys[1], '0);
    send_item(kvat_pkg::OpLookup, stored_keys[1], '0);
    send_item(kvat_pkg::OpLookup, stored_keys[0], '0);
    // Overwriting an existing key keeps its place in the order.
    send_item(kvat_pkg::OpPut, stored_keys[0], 32'h1234_5678);
    send_item(kvat_pkg::OpLookup, stored_keys[0], '1);
    // A miss must not leak the value on the input into the result.
    send_item(kvat_pkg::OpLookup, 32'h5A5A_5A5A, '1);
    // Fill the table up; every insert pushes the older entries back by one.
    for (i = 2; i < Entries; i++) begin
      send_item(kvat_pkg::OpPut, stored_keys[i], $urandom);
    end
    // A new key on a full table is refused, while a put to a key that is
    // already there still goes through, here on the oldest entry.
    send_item(kvat_pkg::OpPut, 32'h8000_0001, '1);
    send_item(kvat_pkg::OpPut, stored_keys[0], 32'hA5A5_A5A5);
    send_item(kvat_pkg::OpLookup, stored_keys[0], '0);

    // Random phases with different idling on the two channels. Before the
    // third phase the sender holds off until the table has answered every
    // item that it took.
    for (phase = 0; phase < PhaseCount; phase++) begin
      calm_source = (phase == 1);
      calm_sink   = (phase == 1) || (phase == 3);
      if (phase == 2) begin
        in_valid <= 1'b0;
        wait_for_results();
      end
      for (i = 0; i < PhaseItems; i++) begin
        send_random_item();
      end
    end

    in_valid <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
